/* rtl/assert_macros.svh */
// Assertion macros for the checker module of the console block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCEC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TCEC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/tcec_pkg.sv */
// Package of shared types and constants for the text console cursor block.
`default_nettype none

package tcec_pkg;

	localparam int unsigned MAX_COLS = 512;
	localparam int unsigned MAX_ROWS = 256;

	localparam int unsigned COLS_W  = 10;
	localparam int unsigned ROWS_W  = 9;
	localparam int unsigned CUR_COL_W = 10;
	localparam int unsigned CUR_ROW_W = 8;
	localparam int unsigned PARAM_W = 16;
	localparam int unsigned CNT_W   = 4;
	localparam int unsigned MAX_PARAMS = 8;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned MAX_RESULTS = 3;

	localparam logic [1:0] CMD_DRAW   = 2'd0;
	localparam logic [1:0] CMD_SCROLL = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic REG_SCREEN_COLS = 1'b0;
	localparam logic REG_SCREEN_ROWS = 1'b1;

	typedef enum logic [3:0] {
		KIND_ESC,
		KIND_LF,
		KIND_CR,
		KIND_TAB,
		KIND_BS,
		KIND_DIGIT,
		KIND_SEMI,
		KIND_LBRACK,
		KIND_FIN_J,
		KIND_FIN_H,
		KIND_FIN_A,
		KIND_FIN_B,
		KIND_FIN_C,
		KIND_FIN_D,
		KIND_OTHER
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic       printable;
		logic [6:0] glyph;
		logic [3:0] digit;
	} item_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [6:0] glyph;
		logic [8:0] col;
		logic [7:0] row;
	} result_t;

endpackage

`default_nettype wire

/* rtl/tcec_front.sv */
// Front end: registers each incoming byte together with its classification.
`default_nettype none

module tcec_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [7:0]     char_byte,
	output logic                item_valid,
	input  wire logic           item_ready,
	output tcec_pkg::item_t     item
);
	import tcec_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t class_d;

	always_comb begin
		class_d.glyph     = char_byte[6:0];
		class_d.digit     = char_byte[3:0];
		class_d.printable = (char_byte >= 8'h20) && (char_byte <= 8'h7F);
		case (char_byte)
			8'h1B:   class_d.kind = KIND_ESC;
			8'h0A:   class_d.kind = KIND_LF;
			8'h0D:   class_d.kind = KIND_CR;
			8'h09:   class_d.kind = KIND_TAB;
			8'h08:   class_d.kind = KIND_BS;
			8'h3B:   class_d.kind = KIND_SEMI;
			8'h5B:   class_d.kind = KIND_LBRACK;
			8'h4A:   class_d.kind = KIND_FIN_J;
			8'h48:   class_d.kind = KIND_FIN_H;
			8'h41:   class_d.kind = KIND_FIN_A;
			8'h42:   class_d.kind = KIND_FIN_B;
			8'h43:   class_d.kind = KIND_FIN_C;
			8'h44:   class_d.kind = KIND_FIN_D;
			default: begin
				if ((char_byte >= 8'h30) && (char_byte <= 8'h39)) begin
					class_d.kind = KIND_DIGIT;
				end else begin
					class_d.kind = KIND_OTHER;
				end
			end
		endcase
	end

	assign in_ready   = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= class_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/tcec_queue.sv */
// Short queue of classified bytes between the front end and the back end.
`default_nettype none

module tcec_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire tcec_pkg::item_t push_item,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output tcec_pkg::item_t     pop_item
);
	import tcec_pkg::*;

	item_t                    mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]      wr_ptr_q;
	logic [QUEUE_AW-1:0]      rd_ptr_q;
	logic [QUEUE_AW:0]        count_q;
	logic                     push;
	logic                     pop;

	assign push_ready = (count_q != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

/* rtl/tcec_back.sv */
// Back end: escape parser, cursor state and the result buffer that feeds the output.
`default_nettype none

module tcec_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [tcec_pkg::COLS_W-1:0] screen_cols,
	input  wire logic [tcec_pkg::ROWS_W-1:0] screen_rows,
	input  wire logic                        item_valid,
	output logic                             item_ready,
	input  wire tcec_pkg::item_t             item,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output tcec_pkg::result_t                result,
	output logic                             result_last
);
	import tcec_pkg::*;

	typedef enum logic [1:0] {
		MODE_TEXT,
		MODE_ESC,
		MODE_CSI
	} mode_t;

	mode_t                 mode_q, mode_d;
	logic [CUR_COL_W-1:0]  cursor_col_q, col_d;
	logic [CUR_ROW_W-1:0]  cursor_row_q;
	logic [PARAM_W-1:0]    accum_q, accum_d;
	logic [PARAM_W-1:0]    first_q, first_d;
	logic [PARAM_W-1:0]    second_q, second_d;
	logic [CNT_W-1:0]      count_q, count_d;

	result_t               res_q [MAX_RESULTS];
	result_t               res_d [MAX_RESULTS];
	logic [1:0]            n_q, k_d;
	logic [1:0]            idx_q;

	logic [COLS_W-1:0]     cols_eff, cols_m1;
	logic [ROWS_W-1:0]     rows_eff, rows_m1;
	logic [CUR_COL_W-1:0]  col_w;
	logic [ROWS_W-1:0]     row_w;
	logic [10:0]           tab_sum;
	logic [19:0]           accum_mul;
	logic [PARAM_W-1:0]    n_v, cl_v;
	logic [16:0]           fin_row, fin_col;

	logic                  take;
	logic                  buf_free;
	logic                  fire;

	always_comb begin
		if (screen_cols == '0) begin
			cols_eff = COLS_W'(1);
		end else if (screen_cols > COLS_W'(MAX_COLS)) begin
			cols_eff = COLS_W'(MAX_COLS);
		end else begin
			cols_eff = screen_cols;
		end
		if (screen_rows == '0) begin
			rows_eff = ROWS_W'(1);
		end else if (screen_rows > ROWS_W'(MAX_ROWS)) begin
			rows_eff = ROWS_W'(MAX_ROWS);
		end else begin
			rows_eff = screen_rows;
		end
		cols_m1 = cols_eff - COLS_W'(1);
		rows_m1 = rows_eff - ROWS_W'(1);
	end

	assign accum_mul = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0} + {16'd0, item.digit};

	always_comb begin
		mode_d   = mode_q;
		accum_d  = accum_q;
		first_d  = first_q;
		second_d = second_q;
		count_d  = count_q;
		col_w    = cursor_col_q;
		row_w    = {1'b0, cursor_row_q};
		k_d      = 2'd0;
		tab_sum  = '0;
		n_v      = '0;
		cl_v     = '0;
		fin_row  = '0;
		fin_col  = '0;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			res_d[i] = '0;
		end
		case (mode_q)
			MODE_ESC: begin
				if (item.kind == KIND_LBRACK) begin
					mode_d  = MODE_CSI;
					count_d = '0;
					accum_d = '0;
				end else begin
					mode_d = MODE_TEXT;
				end
			end
			MODE_CSI: begin
				if (item.kind == KIND_DIGIT) begin
					accum_d = (accum_mul > 20'd65535) ? 16'hFFFF : accum_mul[15:0];
				end else begin
					if (count_q < CNT_W'(MAX_PARAMS)) begin
						if (count_q == CNT_W'(0)) begin
							first_d = accum_q;
						end else if (count_q == CNT_W'(1)) begin
							second_d = accum_q;
						end
						count_d = count_q + CNT_W'(1);
					end
					if (item.kind == KIND_SEMI) begin
						accum_d = '0;
					end else begin
						mode_d  = MODE_TEXT;
						n_v     = (first_d != '0) ? first_d : 16'd1;
						fin_row = {9'd0, cursor_row_q};
						fin_col = {7'd0, cursor_col_q};
						case (item.kind)
							KIND_FIN_J: begin
								if (first_d == 16'd2) begin
									res_d[0].cmd = CMD_CLEAR;
									k_d          = 2'd1;
									fin_row      = '0;
									fin_col      = '0;
								end
							end
							KIND_FIN_H: begin
								cl_v    = ((count_d > CNT_W'(1)) && (second_d != '0)) ?
									second_d : 16'd1;
								fin_row = {1'b0, n_v} - 17'd1;
								fin_col = {1'b0, cl_v} - 17'd1;
								if (fin_col > {7'd0, cols_m1}) begin
									fin_col = {7'd0, cols_m1};
								end
							end
							KIND_FIN_A: begin
								fin_row = (fin_row > {1'b0, n_v}) ? fin_row - {1'b0, n_v} : '0;
							end
							KIND_FIN_B: begin
								fin_row = fin_row + {1'b0, n_v};
							end
							KIND_FIN_C: begin
								fin_col = fin_col + {1'b0, n_v};
								if (fin_col > {7'd0, cols_m1}) begin
									fin_col = {7'd0, cols_m1};
								end
							end
							KIND_FIN_D: begin
								fin_col = (fin_col > {1'b0, n_v}) ? fin_col - {1'b0, n_v} : '0;
							end
							default: begin
							end
						endcase
						if (fin_row > {8'd0, rows_m1}) begin
							fin_row = {8'd0, rows_m1};
						end
						col_w = fin_col[CUR_COL_W-1:0];
						row_w = fin_row[ROWS_W-1:0];
					end
				end
			end
			MODE_TEXT: begin
				case (item.kind)
					KIND_ESC: begin
						mode_d = MODE_ESC;
					end
					KIND_LF: begin
						col_w = '0;
						row_w = row_w + ROWS_W'(1);
					end
					KIND_CR: begin
						col_w = '0;
					end
					KIND_TAB: begin
						tab_sum = ({1'b0, col_w} + 11'd4) & ~11'd3;
						col_w   = (tab_sum > 11'd1023) ? 10'd1023 : tab_sum[9:0];
					end
					KIND_BS: begin
						if (col_w != '0) begin
							col_w = col_w - CUR_COL_W'(1);
						end
					end
					default: begin
						if (item.printable) begin
							if (col_w >= cols_eff) begin
								col_w = '0;
								row_w = row_w + ROWS_W'(1);
							end
							if (row_w >= rows_eff) begin
								res_d[k_d].cmd = CMD_SCROLL;
								k_d            = k_d + 2'd1;
								row_w          = rows_m1;
								col_w          = '0;
							end
							res_d[k_d].cmd   = CMD_DRAW;
							res_d[k_d].glyph = item.glyph;
							res_d[k_d].col   = col_w[8:0];
							res_d[k_d].row   = row_w[7:0];
							k_d              = k_d + 2'd1;
							col_w            = col_w + CUR_COL_W'(1);
							if (col_w >= cols_eff) begin
								col_w = '0;
								row_w = row_w + ROWS_W'(1);
							end
						end
					end
				endcase
				if ((item.kind != KIND_ESC) && (row_w >= rows_eff)) begin
					res_d[k_d].cmd = CMD_SCROLL;
					k_d            = k_d + 2'd1;
					row_w          = rows_m1;
					col_w          = '0;
				end
			end
			default: begin
				mode_d = MODE_TEXT;
			end
		endcase
		col_d = col_w;
	end

	assign out_valid   = (idx_q != n_q);
	assign take        = out_valid && out_ready;
	assign buf_free    = (idx_q == n_q) || (take && ((idx_q + 2'd1) == n_q));
	assign item_ready  = buf_free;
	assign fire        = item_valid && buf_free;
	assign result      = res_q[idx_q];
	assign result_last = ((idx_q + 2'd1) == n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_TEXT;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			accum_q      <= '0;
			first_q      <= '0;
			second_q     <= '0;
			count_q      <= '0;
			n_q          <= '0;
			idx_q        <= '0;
		end else if (fire) begin
			mode_q       <= mode_d;
			cursor_col_q <= col_d;
			cursor_row_q <= row_w[CUR_ROW_W-1:0];
			accum_q      <= accum_d;
			first_q      <= first_d;
			second_q     <= second_d;
			count_q      <= count_d;
			n_q          <= k_d;
			idx_q        <= '0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				res_q[i] <= res_d[i];
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/text_console_escape_cursor.sv */
// Top level of the text console cursor and escape sequence parser.
//
// Bytes arrive on the in_valid/in_ready channel, one byte per request in
// char_byte. Each byte yields zero to three drawing commands (draw glyph,
// scroll up one line, clear screen) on the out_valid/out_ready channel, with
// last marking the final command caused by a byte.
// The screen size is set through the cfg channel: index 0 writes the column
// count, index 1 the row count. Writes are taken at once (cfg_ready is high).
// A byte passes a classify register and a two-entry queue, then the parser
// updates the cursor and loads its commands into a result buffer.
// The parser takes one byte per cycle while its result buffer is free;
// the single result port, which sends commands one by one, sets the rate.
// When the receiver stalls, the result buffer, the queue and the classify
// register fill and in_ready falls; nothing is lost.
// Reset sets the cursor to the top left corner, text mode, a screen of 128 by
// 48 cells, and empties every stage.
`default_nettype none

module text_console_escape_cursor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       command,
	output logic [6:0]       glyph_code,
	output logic [8:0]       cell_col,
	output logic [7:0]       cell_row,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [9:0]  cfg_data
);
	import tcec_pkg::*;

	logic [COLS_W-1:0] screen_cols_q;
	logic [ROWS_W-1:0] screen_rows_q;

	logic    front_valid, front_ready;
	item_t   front_item;
	logic    queue_valid, queue_ready;
	item_t   queue_item;
	result_t result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_cols_q <= COLS_W'(128);
			screen_rows_q <= ROWS_W'(48);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCREEN_COLS: screen_cols_q <= cfg_data;
				REG_SCREEN_ROWS: screen_rows_q <= cfg_data[ROWS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tcec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_byte  (char_byte),
		.item_valid (front_valid),
		.item_ready (front_ready),
		.item       (front_item)
	);

	tcec_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_item  (front_item),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_item   (queue_item)
	);

	tcec_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.screen_cols (screen_cols_q),
		.screen_rows (screen_rows_q),
		.item_valid  (queue_valid),
		.item_ready  (queue_ready),
		.item        (queue_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result      (result),
		.result_last (last)
	);

	assign command    = result.cmd;
	assign glyph_code = result.glyph;
	assign cell_col   = result.col;
	assign cell_row   = result.row;

endmodule

`default_nettype wire

/* rtl/tcec_checker.sv */
// Port checker for the text console cursor block and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module tcec_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] command,
	input wire logic [6:0] glyph_code,
	input wire logic [8:0] cell_col,
	input wire logic [7:0] cell_row,
	input wire logic       last
);
	import tcec_pkg::*;

	`TCEC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(command) && $stable(glyph_code) && $stable(cell_col) && $stable(cell_row) && $stable(last))
	`TCEC_ASSERT_IMP(a_plain_payload, clk, arst_n, out_valid && (command != CMD_DRAW), (glyph_code == 7'd0) && (cell_col == 9'd0) && (cell_row == 8'd0))
	`TCEC_ASSERT_IMP(a_draw_printable, clk, arst_n, out_valid && (command == CMD_DRAW), glyph_code >= 7'h20)
	`TCEC_ASSERT_IMP(a_clear_alone, clk, arst_n, out_valid && (command == CMD_CLEAR), last)

endmodule

bind text_console_escape_cursor tcec_checker u_checker (.*);

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the text console cursor and escape sequence parser.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tcec_pkg::*;

	typedef enum logic [1:0] {
		PM_TEXT,
		PM_ESC,
		PM_CSI
	} parse_mode_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [6:0] glyph;
		logic [8:0] col;
		logic [7:0] row;
		logic       last;
	} console_cmd_t;

	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_LBRACK = "[";
	localparam logic [7:0] CH_SEMI   = ";";
	localparam logic [7:0] CH_0      = "0";
	localparam logic [7:0] CH_9      = "9";
	localparam logic [7:0] FIN_J     = "J";
	localparam logic [7:0] FIN_H     = "H";
	localparam logic [7:0] FIN_A     = "A";
	localparam logic [7:0] FIN_B     = "B";
	localparam logic [7:0] FIN_C     = "C";
	localparam logic [7:0] FIN_D     = "D";
	localparam logic [7:0] FIN_M     = "m";
	localparam int unsigned PARAM_MAX = 65535;
	localparam int unsigned COL_HOLD = 1023;
	localparam int SETTLE_CYCLES = 12;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] char_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] command;
	logic [6:0] glyph_code;
	logic [8:0] cell_col;
	logic [7:0] cell_row;
	logic       last;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_index = 1'b0;
	logic [9:0] cfg_data = 10'd0;

	logic [7:0]   pending_bytes [$];
	console_cmd_t expected_cmds [$];
	logic         in_taken = 1'b0;
	int unsigned  in_idle_pct = 0;
	int unsigned  out_stall_pct = 0;
	int           fail_count = 0;

	// Shadow of the console state used to predict the command stream.
	logic [9:0]   cols_reg = 10'd128;
	logic [8:0]   rows_reg = 9'd48;
	parse_mode_t  mode = PM_TEXT;
	int unsigned  cur_col = 0;
	int unsigned  cur_row = 0;
	int unsigned  accum = 0;
	int unsigned  param1 = 0;
	int unsigned  param2 = 0;
	int unsigned  param_cnt = 0;
	console_cmd_t step_cmds [0:2];
	int           step_n = 0;

	text_console_escape_cursor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_byte (char_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.command   (command),
		.glyph_code(glyph_code),
		.cell_col  (cell_col),
		.cell_row  (cell_row),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned eff_cols();
		int unsigned c;
		c = cols_reg;
		if (c < 1) c = 1;
		if (c > MAX_COLS) c = MAX_COLS;
		return c;
	endfunction

	function automatic int unsigned eff_rows();
		int unsigned r;
		r = rows_reg;
		if (r < 1) r = 1;
		if (r > MAX_ROWS) r = MAX_ROWS;
		return r;
	endfunction

	task automatic add_cmd(input logic [1:0] cmd, input logic [7:0] glyph,
			input int unsigned col, input int unsigned row);
		step_cmds[step_n].cmd = cmd;
		step_cmds[step_n].glyph = glyph[6:0];
		step_cmds[step_n].col = col[8:0];
		step_cmds[step_n].row = row[7:0];
		step_cmds[step_n].last = 1'b0;
		step_n++;
	endtask

	task automatic scroll_if_below();
		if (cur_row >= eff_rows()) begin
			add_cmd(CMD_SCROLL, 8'h00, 0, 0);
			cur_row = eff_rows() - 1;
			cur_col = 0;
		end
	endtask

	task automatic apply_csi_final(input logic [7:0] c);
		int unsigned cols;
		int unsigned n;
		int unsigned r;
		int unsigned cl;
		cols = eff_cols();
		n = (param1 > 0) ? param1 : 1;
		if (c == FIN_J) begin
			if (param1 == 2) begin
				add_cmd(CMD_CLEAR, 8'h00, 0, 0);
				cur_col = 0;
				cur_row = 0;
			end
		end else if (c == FIN_H) begin
			r = (param1 > 0) ? param1 : 1;
			cl = (param_cnt > 1 && param2 > 0) ? param2 : 1;
			cur_row = r - 1;
			cur_col = cl - 1;
			if (cur_col > cols - 1) cur_col = cols - 1;
		end else if (c == FIN_A) begin
			cur_row = (cur_row > n) ? cur_row - n : 0;
		end else if (c == FIN_B) begin
			cur_row = cur_row + n;
		end else if (c == FIN_C) begin
			cur_col = cur_col + n;
			if (cur_col > cols - 1) cur_col = cols - 1;
		end else if (c == FIN_D) begin
			cur_col = (cur_col > n) ? cur_col - n : 0;
		end
		if (cur_row > eff_rows() - 1) cur_row = eff_rows() - 1;
		mode = PM_TEXT;
	endtask

	task automatic predict_commands(input logic [7:0] c);
		int unsigned cols;
		int unsigned v;
		int i;
		cols = eff_cols();
		step_n = 0;
		case (mode)
			PM_ESC: begin
				if (c == CH_LBRACK) begin
					mode = PM_CSI;
					param_cnt = 0;
					accum = 0;
				end else begin
					mode = PM_TEXT;
				end
			end
			PM_CSI: begin
				if (c >= CH_0 && c <= CH_9) begin
					v = accum * 10 + (c - CH_0);
					accum = (v > PARAM_MAX) ? PARAM_MAX : v;
				end else begin
					if (param_cnt < MAX_PARAMS) begin
						if (param_cnt == 0) param1 = accum;
						else if (param_cnt == 1) param2 = accum;
						param_cnt++;
					end
					if (c == CH_SEMI) accum = 0;
					else apply_csi_final(c);
				end
			end
			PM_TEXT: begin
				if (c == CH_ESC) begin
					mode = PM_ESC;
				end else begin
					if (c == CH_LF) begin
						cur_col = 0;
						cur_row++;
					end else if (c == CH_CR) begin
						cur_col = 0;
					end else if (c == CH_TAB) begin
						v = (cur_col + 4) & ~32'd3;
						cur_col = (v > COL_HOLD) ? COL_HOLD : v;
					end else if (c == CH_BS) begin
						if (cur_col > 0) cur_col--;
					end else if (c >= 8'h20 && c <= 8'h7F) begin
						if (cur_col >= cols) begin
							cur_col = 0;
							cur_row++;
						end
						scroll_if_below();
						add_cmd(CMD_DRAW, c, cur_col, cur_row);
						cur_col++;
						if (cur_col >= cols) begin
							cur_col = 0;
							cur_row++;
						end
					end
					scroll_if_below();
				end
			end
			default: mode = PM_TEXT;
		endcase
		if (step_n > 0) step_cmds[step_n - 1].last = 1'b1;
		for (i = 0; i < step_n; i++) expected_cmds.push_back(step_cmds[i]);
	endtask

	// Sampling side: requests feed the prediction, results are checked in order.
	always @(posedge clk) begin : monitor
		console_cmd_t want;
		console_cmd_t got;
		in_taken = in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) predict_commands(char_byte);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SCREEN_COLS) cols_reg = cfg_data;
				else rows_reg = cfg_data[8:0];
			end
			if (out_valid && out_ready) begin
				got.cmd = command;
				got.glyph = glyph_code;
				got.col = cell_col;
				got.row = cell_row;
				got.last = last;
				if (expected_cmds.size() == 0) begin
					$display("%0t: unexpected command: got cmd %0d glyph %0d col %0d row %0d last %0d",
						$time, got.cmd, got.glyph, got.col, got.row, got.last);
					fail_count++;
				end else begin
					want = expected_cmds.pop_front();
					if (got !== want) begin
						$display("%0t: command mismatch: expected cmd %0d glyph %0d col %0d row %0d last %0d",
							$time, want.cmd, want.glyph, want.col, want.row, want.last);
						$display("%0t:                   actual cmd %0d glyph %0d col %0d row %0d last %0d",
							$time, got.cmd, got.glyph, got.col, got.row, got.last);
						fail_count++;
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= in_idle_pct) begin
				in_valid <= 1'b1;
				char_byte <= pending_bytes.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
	end

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_cmds.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [9:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_burst(inout int n_sent);
		int unsigned pick;
		int unsigned len;
		int unsigned nparm;
		int unsigned ndig;
		int unsigned start;
		int unsigned i;
		int unsigned j;
		logic [7:0] b;
		logic [7:0] fin;
		pick = $urandom_range(0, 99);
		start = pending_bytes.size();
		if (pick < 35) begin
			len = $urandom_range(1, 6);
			for (i = 0; i < len; i++) begin
				b = $urandom_range(8'h20, 8'h7F);
				pending_bytes.push_back(b);
			end
		end else if (pick < 50) begin
			case ($urandom_range(0, 3))
				0: b = CH_LF;
				1: b = CH_CR;
				2: b = CH_TAB;
				default: b = CH_BS;
			endcase
			pending_bytes.push_back(b);
		end else if (pick < 85) begin
			case ($urandom_range(0, 7))
				0: fin = FIN_J;
				1: fin = FIN_H;
				2: fin = FIN_A;
				3: fin = FIN_B;
				4: fin = FIN_C;
				5: fin = FIN_D;
				6: fin = FIN_M;
				default: begin
					do fin = $urandom_range(0, 255);
					while ((fin >= CH_0 && fin <= CH_9) || fin == CH_SEMI);
				end
			endcase
			pending_bytes.push_back(CH_ESC);
			pending_bytes.push_back(CH_LBRACK);
			if (fin == FIN_J && $urandom_range(0, 1) == 1) begin
				pending_bytes.push_back("2");
			end else begin
				nparm = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 11)
					: $urandom_range(0, 2);
				for (i = 0; i < nparm; i++) begin
					if (i > 0) pending_bytes.push_back(CH_SEMI);
					ndig = ($urandom_range(0, 7) == 0) ? 6 : $urandom_range(0, 3);
					for (j = 0; j < ndig; j++) begin
						b = CH_0 + $urandom_range(0, 9);
						pending_bytes.push_back(b);
					end
				end
			end
			pending_bytes.push_back(fin);
		end else if (pick < 92) begin
			do b = $urandom_range(0, 255);
			while (b == CH_LBRACK);
			pending_bytes.push_back(CH_ESC);
			pending_bytes.push_back(b);
		end else begin
			// Bytes the block ignores in text mode do not count towards the quota.
			if ($urandom_range(0, 1) == 1) begin
				b = $urandom_range(8'h80, 8'hFF);
			end else begin
				do b = $urandom_range(8'h00, 8'h1F);
				while (b == CH_ESC || b == CH_LF || b == CH_CR || b == CH_TAB || b == CH_BS);
			end
			pending_bytes.push_back(b);
			start = pending_bytes.size();
		end
		n_sent += pending_bytes.size() - start;
	endtask

	task automatic run_phase(input logic [9:0] cols, input logic [9:0] rows,
			input int unsigned idle, input int unsigned stall, input int n_items);
		int sent;
		wait_idle();
		write_reg(REG_SCREEN_COLS, cols);
		write_reg(REG_SCREEN_ROWS, rows);
		in_idle_pct = idle;
		out_stall_pct = stall;
		sent = 0;
		while (sent < n_items) queue_burst(sent);
	endtask

	initial begin
		int k;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		pending_bytes.push_back("A");
		pending_bytes.push_back(8'h20);
		pending_bytes.push_back(8'h7F);
		pending_bytes.push_back(CH_TAB);
		pending_bytes.push_back(CH_BS);
		pending_bytes.push_back(CH_CR);
		pending_bytes.push_back(CH_BS);
		pending_bytes.push_back(CH_LF);
		pending_bytes.push_back(8'h00);
		pending_bytes.push_back(8'hFF);
		pending_bytes.push_back(CH_ESC);
		pending_bytes.push_back("x");
		pending_bytes.push_back(CH_ESC);
		pending_bytes.push_back(CH_LBRACK);
		pending_bytes.push_back("2");
		pending_bytes.push_back(FIN_J);
		pending_bytes.push_back(CH_ESC);
		pending_bytes.push_back(CH_LBRACK);
		for (k = 0; k < 6; k++) pending_bytes.push_back(CH_9);
		pending_bytes.push_back(FIN_B);
		pending_bytes.push_back(CH_LF);
		k = 0;
		while (k < 30) queue_burst(k);

		run_phase(10'd1, 10'd1, 76, 0, 35);
		run_phase(10'd0, 10'd0, 0, 76, 35);
		run_phase(10'd512, 10'd256, 35, 35, 35);
		run_phase(10'd1023, 10'd1023, 0, 0, 35);
		run_phase(10'd80, 10'd25, 76, 0, 35);
		run_phase(10'd7, 10'd3, 0, 76, 35);

		wait_idle();
		if (fail_count == 0 && expected_cmds.size() == 0) begin
			$display("text_console_escape_cursor regression: pass");
		end else begin
			$display("text_console_escape_cursor regression: fail");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("text_console_escape_cursor regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/tcec_pkg.sv
rtl/tcec_front.sv
rtl/tcec_queue.sv
rtl/tcec_back.sv
rtl/text_console_escape_cursor.sv
rtl/tcec_checker.sv
dv/tb_top.sv
